// File: design/wpm_pkg.sv
`default_nettype none

package wpm_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;

    // wildcard bytes
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic       restart;  // accepted restart word
        logic       text;     // accepted text word
        logic       load;     // accepted load word
        logic [7:0] symbol;   // pattern byte or text byte
    } ctrl_t;

endpackage

`default_nettype wire

// File: design/wildcard_pattern_matcher.sv
// an accepted input word's result word is registered and appears in the next cycle
// throughput: one word per cycle unless stalled; the star chain and
//   the star-prefix seed ripple through the row of cells in that cycle
// reset: match bits clear, empty-prefix bit set, pattern_length 0, no result
//   pending; pattern bytes hold no reset value until loaded
`default_nettype none

module wildcard_pattern_matcher #(
    parameter int MAX_PATTERN = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration: pattern_length
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data,
    // input words
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] opcode,
    input  wire logic [5:0] position,
    input  wire logic [7:0] symbol,
    // result words
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            full_match,
    output logic            still_alive
);

    // length register is wide enough to hold MAX_PATTERN itself
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]     len_reg;
    logic                 empty_reg;
    logic                 empty_next;
    logic                 out_valid_reg;
    logic                 full_reg;
    logic                 alive_reg;
    logic                 accept;
    wpm_pkg::ctrl_t       ctrl;

    logic [MAX_PATTERN-1:0] match_vec;   // current bit of prefix i+1
    logic [MAX_PATTERN-1:0] next_vec;    // updated bit of prefix i+1
    logic [MAX_PATTERN:0]   run_vec;     // star-prefix seed chain
    logic [MAX_PATTERN:0]   pfx_next;    // updated bits, empty prefix at 0
    logic [MAX_PATTERN:0]   live_mask;   // prefixes 0..pattern_length
    logic                   full_calc;
    logic                   alive_calc;

    // cfg takes every write, unchecked; user must write only while idle
    assign cfg_ready = 1'b1;

    // output register frees up in the same cycle it is taken
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        ctrl         = '0;
        ctrl.symbol  = symbol;
        if (accept)
        begin
            case (opcode)
                wpm_pkg::OP_LOAD:    ctrl.load    = 1'b1;
                wpm_pkg::OP_RESTART: ctrl.restart = 1'b1;
                wpm_pkg::OP_TEXT:    ctrl.text    = 1'b1;
                default:             ctrl.load    = 1'b0;  // ignored word
            endcase
        end
    end

    // empty prefix matches only the empty text
    always_comb
    begin
        if (ctrl.restart)
        begin
            empty_next = 1'b1;
        end
        else if (ctrl.text)
        begin
            empty_next = 1'b0;
        end
        else
        begin
            empty_next = empty_reg;
        end
    end

    // row of cells, one per pattern position
    // each cell sees the old bit of its left neighbor (diagonal step) and
    // the new bit of its left neighbor (star chain)
    assign run_vec[0] = 1'b1;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic left_bit;
        logic chain_bit;
        logic sel;

        if (i == 0)
        begin : g_first
            assign left_bit  = empty_reg;
            assign chain_bit = empty_next;
        end
        else
        begin : g_rest
            assign left_bit  = match_vec[i-1];
            assign chain_bit = next_vec[i-1];
        end

        assign sel = (32'(position) == i);

        wpm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .load_sel (sel),
            .left_in  (left_bit),
            .chain_in (chain_bit),
            .run_in   (run_vec[i]),
            .match_out(match_vec[i]),
            .next_out (next_vec[i]),
            .run_out  (run_vec[i+1])
        );
    end

    // result from the updated bits, pattern_length picks the full prefix
    assign pfx_next = {next_vec, empty_next};

    always_comb
    begin
        for (int k = 0; k <= MAX_PATTERN; k++)
        begin
            live_mask[k] = (k <= 32'(len_reg));
        end
    end

    assign full_calc  = pfx_next[len_reg] && (ctrl.restart || ctrl.text);
    assign alive_calc = |(pfx_next & live_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                // lengths beyond the row saturate
                if (32'(cfg_data) > MAX_PATTERN)
                begin
                    len_reg <= LEN_W'(MAX_PATTERN);
                end
                else
                begin
                    len_reg <= LEN_W'(cfg_data);
                end
            end
            empty_reg <= empty_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            full_reg  <= full_calc;
            alive_reg <= alive_calc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign full_match  = full_reg;
    assign still_alive = alive_reg;

endmodule

`default_nettype wire

// File: design/wpm_cell.sv
`default_nettype none

module wpm_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire wpm_pkg::ctrl_t ctrl,
    input  wire logic           load_sel,
    input  wire logic           left_in,
    input  wire logic           chain_in,
    input  wire logic           run_in,
    output logic                match_out,
    output logic                next_out,
    output logic                run_out
);

    logic [7:0] pat_reg;
    logic       match_reg;
    logic       match_next;
    logic       is_star;
    logic       hit;
    logic       text_bit;

    assign is_star = (pat_reg == wpm_pkg::STAR_BYTE);
    assign hit     = (pat_reg == wpm_pkg::ANY_BYTE) || (pat_reg == ctrl.symbol);

    // star keeps its own bit or takes the new bit of its left neighbor
    assign text_bit = is_star ? (match_reg | chain_in) : (hit & left_in);
    assign run_out  = run_in & is_star;

    always_comb
    begin
        if (ctrl.restart)
        begin
            match_next = run_out;
        end
        else if (ctrl.text)
        begin
            match_next = text_bit;
        end
        else
        begin
            match_next = match_reg;
        end
    end

    assign match_out = match_reg;
    assign next_out  = match_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && load_sel)
        begin
            pat_reg <= ctrl.symbol;
        end
    end

endmodule

`default_nettype wire

// File: design/wpm_checker.sv
`default_nettype none

module wpm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] opcode,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       full_match,
    input wire logic       still_alive
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(full_match) && $stable(still_alive))
        else $error("result word changed while stalled");

    // the full prefix is one of the live prefixes
    a_full_alive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_match |-> still_alive)
        else $error("full match without a live prefix");

    // a load answers with no full match in the next cycle
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == wpm_pkg::OP_LOAD) |=> out_valid && !full_match)
        else $error("load word answered with a full match");

    // an empty output side never blocks input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .full_match (full_match),
    .still_alive(still_alive)
);

`default_nettype wire
